// ===== hdl/emsc_pkg.sv =====
package emsc_pkg;

    // Default widths of the configurable datapath
    localparam int COEF_WIDTH_DEF  = 21;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int SCORE_WIDTH_DEF = 36;

    // Fixed formats: Q12.4 points, Q8.12 thresholds and distances
    localparam int COORD_FRAC = 4;
    localparam int ONE_PIXEL  = 1 << COORD_FRAC;
    localparam int THR_WIDTH  = 20;
    localparam int QUOT_WIDTH = THR_WIDTH + 1;
    localparam logic [QUOT_WIDTH-1:0] DIST_CAP = QUOT_WIDTH'(1) << THR_WIDTH;

    // Register reset values
    localparam logic [THR_WIDTH-1:0] CHI_RESET   = THR_WIDTH'(15733);
    localparam logic [THR_WIDTH-1:0] BONUS_RESET = THR_WIDTH'(24539);

    // Register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_ONE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_TWO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_THREE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHI       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BONUS     = 3'd4;

endpackage

// ===== hdl/emsc_front.sv =====
module emsc_front #(
    parameter int ITEM_W = 65
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [ITEM_W-1:0] i_item,
    output logic              o_empty,
    input  logic              i_pop,
    output logic [ITEM_W-1:0] o_item
);

    logic [ITEM_W-1:0] r_mem [2];
    logic              r_wr;
    logic              r_rd;
    logic [1:0]        r_cnt;
    logic              push_ok;
    logic              pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd];

    // Two-entry item queue between intake and the scoring sequencer
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_item;
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wr <= ~r_wr;
            end
            if (pop_ok) begin
                r_rd <= ~r_rd;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

// ===== hdl/emsc_mul.sv =====
module emsc_mul #(
    parameter int MW = 56
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [MW-1:0]   i_a,
    input  logic [MW-1:0]   i_b,
    output logic            o_done,
    output logic [2*MW-1:0] o_prod
);

    logic [2*MW-1:0] r_a;
    logic [MW-1:0]   r_b;
    logic [2*MW-1:0] r_acc;
    logic            r_busy;

    assign o_done = r_busy && (r_b == '0);
    assign o_prod = r_acc;

    // Shift-add: one multiplier bit per cycle, stop once the rest is zero
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= (2*MW)'(i_a);
            r_b   <= i_b;
        end else if (r_busy && (r_b != '0)) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

endmodule

// ===== hdl/emsc_div.sv =====
module emsc_div #(
    parameter int XW = 116,
    parameter int DW = 77
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [XW-1:0]                    i_x,
    input  logic [DW-1:0]                    i_den,
    output logic                             o_done,
    output logic [emsc_pkg::QUOT_WIDTH-1:0]  o_quot
);
    import emsc_pkg::*;

    localparam int VW = ((XW > DW + QUOT_WIDTH) ? XW : DW + QUOT_WIDTH) + 1;
    localparam int CW = $clog2(QUOT_WIDTH + 1);

    logic [VW-1:0]         r_x;
    logic [VW-1:0]         r_t;
    logic [QUOT_WIDTH-1:0] r_q;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy;
    logic [VW-1:0]         x_ext;
    logic [VW-1:0]         den_cap;
    logic                  fit;

    assign x_ext   = VW'(i_x);
    assign den_cap = VW'(i_den) << QUOT_WIDTH;
    assign fit     = (r_x >= r_t);
    assign o_done  = r_busy && (r_cnt == '0);
    assign o_quot  = (r_q > DIST_CAP) ? DIST_CAP : r_q;

    // Restoring division, one quotient bit per cycle; large ratios clip at once
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= x_ext;
            r_t <= VW'(i_den) << (QUOT_WIDTH - 1);
            if (x_ext >= den_cap) begin
                r_q   <= DIST_CAP;
                r_cnt <= '0;
            end else begin
                r_q   <= '0;
                r_cnt <= CW'(QUOT_WIDTH);
            end
        end else if (r_busy && (r_cnt != '0)) begin
            if (fit) begin
                r_x <= r_x - r_t;
            end
            r_q   <= {r_q[QUOT_WIDTH-2:0], fit};
            r_t   <= r_t >> 1;
            r_cnt <= r_cnt - CW'(1);
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

endmodule

// ===== hdl/emsc_back.sv =====
module emsc_back #(
    parameter int COEF_WIDTH  = 21,
    parameter int COORD_WIDTH = 16,
    parameter int SCORE_WIDTH = 36
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_empty,
    output logic                            o_q_pop,
    input  logic [4*COORD_WIDTH:0]          i_q_item,
    input  logic [3*COEF_WIDTH-1:0]         i_rows [3],
    input  logic [emsc_pkg::THR_WIDTH-1:0]  i_chi,
    input  logic [emsc_pkg::THR_WIDTH-1:0]  i_bonus,
    output logic                            o_empty,
    input  logic                            i_pop,
    output logic [SCORE_WIDTH-1:0]          o_total_score,
    output logic                            o_score_saturated,
    output logic                            o_degenerate_seen
);
    import emsc_pkg::*;

    // Magnitude widths: line coefficient, numerator, multiplier operand
    localparam int LM    = COEF_WIDTH + COORD_WIDTH + 1;
    localparam int NM    = LM + COORD_WIDTH + 2;
    localparam int MW    = NM;
    localparam int PW    = 2 * MW;
    localparam int DEN_W = 2 * LM + 1;
    localparam int X_W   = PW + COORD_FRAC;
    localparam int CRW   = COORD_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE, S_MSTART, S_MWAIT, S_DSTART, S_DWAIT, S_NEXT, S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_LINE, PH_NUM, PH_DEN, PH_SQR
    } t_phase;

    t_state                 r_state;
    t_phase                 r_ph;
    logic                   r_term;
    logic [1:0]             r_j;
    logic [1:0]             r_k;
    logic [CRW-1:0]         r_u1, r_v1, r_u2, r_v2;
    logic                   r_last;
    logic signed [LM:0]     r_line [3];
    logic signed [NM:0]     r_num;
    logic [DEN_W-1:0]       r_den;
    logic [PW-1:0]          r_xsq;
    logic [SCORE_WIDTH-1:0] r_acc;
    logic                   r_sat;
    logic                   r_deg;
    logic                   r_out_valid;
    logic [SCORE_WIDTH-1:0] r_out_total;
    logic                   r_out_sat;
    logic                   r_out_deg;

    logic [1:0]                 rr, cc;
    logic [3*COEF_WIDTH-1:0]    row_sel;
    logic signed [COEF_WIDTH-1:0] coef;
    logic [COEF_WIDTH-1:0]      coef_mag;
    logic signed [LM:0]         line_k;
    logic [LM:0]                line_mag;
    logic [NM:0]                num_mag;
    logic [MW-1:0]              p_sel, q_sel;
    logic [MW-1:0]              m_a, m_b;
    logic                       m_neg;
    logic                       mul_done;
    logic [PW-1:0]              prod;
    logic signed [LM:0]         line_tr, line_base, line_new;
    logic signed [NM:0]         num_tr, num_base, num_new;
    logic [DEN_W-1:0]           den_new;
    logic                       div_done;
    logic [QUOT_WIDTH-1:0]      sq_dist;
    logic [QUOT_WIDTH-1:0]      chi_ext, bonus_ext, term;
    logic [SCORE_WIDTH:0]       sum;

    // Pick matrix entry: rows for the current-image line, columns for the other
    assign rr       = r_term ? r_k : r_j;
    assign cc       = r_term ? r_j : r_k;
    assign row_sel  = i_rows[rr];
    assign coef     = $signed(row_sel[cc*COEF_WIDTH +: COEF_WIDTH]);
    assign coef_mag = coef[COEF_WIDTH-1] ? COEF_WIDTH'(-coef) : COEF_WIDTH'(coef);
    assign line_k   = r_line[r_k];
    assign line_mag = line_k[LM] ? (LM+1)'(-line_k) : (LM+1)'(line_k);
    assign num_mag  = r_num[NM] ? (NM+1)'(-r_num) : (NM+1)'(r_num);

    // Point for the line product and point tested against the line
    always_comb begin
        case (r_k)
            2'd0: begin
                p_sel = r_term ? MW'(r_u2) : MW'(r_u1);
                q_sel = r_term ? MW'(r_u1) : MW'(r_u2);
            end
            2'd1: begin
                p_sel = r_term ? MW'(r_v2) : MW'(r_v1);
                q_sel = r_term ? MW'(r_v1) : MW'(r_v2);
            end
            default: begin
                p_sel = MW'(ONE_PIXEL);
                q_sel = MW'(ONE_PIXEL);
            end
        endcase
    end

    // Multiplier operands for each phase
    always_comb begin
        case (r_ph)
            PH_LINE: begin
                m_a   = MW'(coef_mag);
                m_b   = p_sel;
                m_neg = coef[COEF_WIDTH-1];
            end
            PH_NUM: begin
                m_a   = MW'(line_mag);
                m_b   = q_sel;
                m_neg = line_k[LM];
            end
            PH_DEN: begin
                m_a   = MW'(line_mag);
                m_b   = MW'(line_mag);
                m_neg = 1'b0;
            end
            default: begin
                m_a   = MW'(num_mag);
                m_b   = MW'(num_mag);
                m_neg = 1'b0;
            end
        endcase
    end

    emsc_mul #(.MW(MW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_MSTART),
        .i_a     (m_a),
        .i_b     (m_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    emsc_div #(.XW(X_W), .DW(DEN_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == S_DSTART) && (r_den != '0)),
        .i_x     ({r_xsq, COORD_FRAC'(0)}),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (sq_dist)
    );

    // Signed accumulation of products; the first product of a sum replaces it
    assign line_tr   = $signed(prod[LM:0]);
    assign line_base = (r_k == 2'd0) ? '0 : r_line[r_j];
    assign line_new  = line_base + (m_neg ? -line_tr : line_tr);
    assign num_tr    = $signed(prod[NM:0]);
    assign num_base  = (r_k == 2'd0) ? '0 : r_num;
    assign num_new   = num_base + (m_neg ? -num_tr : num_tr);
    assign den_new   = ((r_k == 2'd0) ? '0 : r_den) + prod[DEN_W-1:0];

    // Inlier term and saturating sum
    assign chi_ext   = QUOT_WIDTH'(i_chi);
    assign bonus_ext = QUOT_WIDTH'(i_bonus);
    assign term      = (bonus_ext > sq_dist) ? bonus_ext - sq_dist : '0;
    assign sum       = (SCORE_WIDTH+1)'(r_acc) + (SCORE_WIDTH+1)'(term);

    assign o_q_pop           = (r_state == S_IDLE) && !i_q_empty;
    assign o_empty           = !r_out_valid;
    assign o_total_score     = r_out_total;
    assign o_score_saturated = r_out_sat;
    assign o_degenerate_seen = r_out_deg;

    // Sequencer: two distance terms per pair, then the result on a last pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_sat       <= 1'b0;
            r_deg       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_u1    <= i_q_item[CRW-1:0];
                        r_v1    <= i_q_item[2*CRW-1:CRW];
                        r_u2    <= i_q_item[3*CRW-1:2*CRW];
                        r_v2    <= i_q_item[4*CRW-1:3*CRW];
                        r_last  <= i_q_item[4*CRW];
                        r_term  <= 1'b0;
                        r_ph    <= PH_LINE;
                        r_j     <= 2'd0;
                        r_k     <= 2'd0;
                        r_state <= S_MSTART;
                    end
                end
                S_MSTART: begin
                    r_state <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (mul_done) begin
                        r_state <= (r_ph == PH_SQR) ? S_DSTART : S_MSTART;
                        case (r_ph)
                            PH_LINE: begin
                                r_line[r_j] <= line_new;
                                if (r_k == 2'd2) begin
                                    r_k <= 2'd0;
                                    if (r_j == 2'd2) begin
                                        r_j  <= 2'd0;
                                        r_ph <= PH_NUM;
                                    end else begin
                                        r_j <= r_j + 2'd1;
                                    end
                                end else begin
                                    r_k <= r_k + 2'd1;
                                end
                            end
                            PH_NUM: begin
                                r_num <= num_new;
                                if (r_k == 2'd2) begin
                                    r_k  <= 2'd0;
                                    r_ph <= PH_DEN;
                                end else begin
                                    r_k <= r_k + 2'd1;
                                end
                            end
                            PH_DEN: begin
                                r_den <= den_new;
                                if (r_k == 2'd1) begin
                                    r_k  <= 2'd0;
                                    r_ph <= PH_SQR;
                                end else begin
                                    r_k <= r_k + 2'd1;
                                end
                            end
                            default: begin
                                r_xsq <= prod;
                            end
                        endcase
                    end
                end
                S_DSTART: begin
                    // Drop a term whose line has zero norm
                    if (r_den == '0) begin
                        r_deg   <= 1'b1;
                        r_state <= S_NEXT;
                    end else begin
                        r_state <= S_DWAIT;
                    end
                end
                S_DWAIT: begin
                    if (div_done) begin
                        if (sq_dist < chi_ext) begin
                            if (sum[SCORE_WIDTH]) begin
                                r_acc <= '1;
                                r_sat <= 1'b1;
                            end else begin
                                r_acc <= sum[SCORE_WIDTH-1:0];
                            end
                        end
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (!r_term) begin
                        r_term  <= 1'b1;
                        r_ph    <= PH_LINE;
                        r_state <= S_MSTART;
                    end else if (r_last) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    // Hold until the result register is free, then clear the set
                    if (!r_out_valid || i_pop) begin
                        r_out_valid <= 1'b1;
                        r_out_total <= r_acc;
                        r_out_sat   <= r_sat;
                        r_out_deg   <= r_deg;
                        r_acc       <= '0;
                        r_sat       <= 1'b0;
                        r_deg       <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/epipolar_model_score.sv =====
// Channel   | Handshake          | Payload
// ----------+--------------------+-------------------------------------------
// pairs in  | push / full        | i_ref_x, i_ref_y, i_cur_x, i_cur_y,
//           |                    | i_last_match
// score out | empty / pop        | o_total_score, o_score_saturated,
//           |                    | o_degenerate_seen
// config    | i_cfg_we           | i_cfg_index, i_cfg_data
//
// A pair runs two terms, each 15 multiplies and a divide on one shift-add multiplier.
// A multiply steps through the bits of its second operand (at most 16 for line and
// numerator products, 56 for squares); a divide that clips skips its quotient steps.
// A two-pair queue takes input while the sequencer works; a last pair stalls while a
// total waits unpopped. Reset clears queue, score, flags; rows 0, thresholds 3.841/5.991.
module epipolar_model_score #(
    parameter int COEF_WIDTH  = emsc_pkg::COEF_WIDTH_DEF,
    parameter int COORD_WIDTH = emsc_pkg::COORD_WIDTH_DEF,
    parameter int SCORE_WIDTH = emsc_pkg::SCORE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [COORD_WIDTH-1:0]         i_ref_x,
    input  logic [COORD_WIDTH-1:0]         i_ref_y,
    input  logic [COORD_WIDTH-1:0]         i_cur_x,
    input  logic [COORD_WIDTH-1:0]         i_cur_y,
    input  logic                           i_last_match,
    output logic                           empty,
    input  logic                           pop,
    output logic [SCORE_WIDTH-1:0]         o_total_score,
    output logic                           o_score_saturated,
    output logic                           o_degenerate_seen,
    input  logic                           i_cfg_we,
    input  logic [emsc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [3*COEF_WIDTH-1:0]        i_cfg_data
);
    import emsc_pkg::*;

    localparam int ITEM_W = 4 * COORD_WIDTH + 1;

    logic [3*COEF_WIDTH-1:0] r_row [3];
    logic [THR_WIDTH-1:0]    r_chi;
    logic [THR_WIDTH-1:0]    r_bonus;
    logic                    q_empty;
    logic                    q_pop;
    logic [ITEM_W-1:0]       q_item;

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= '0;
            r_row[1] <= '0;
            r_row[2] <= '0;
            r_chi    <= CHI_RESET;
            r_bonus  <= BONUS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROW_ONE:   r_row[0] <= i_cfg_data;
                CFG_ROW_TWO:   r_row[1] <= i_cfg_data;
                CFG_ROW_THREE: r_row[2] <= i_cfg_data;
                CFG_CHI:       r_chi    <= i_cfg_data[THR_WIDTH-1:0];
                CFG_BONUS:     r_bonus  <= i_cfg_data[THR_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    emsc_front #(.ITEM_W(ITEM_W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  ({i_last_match, i_cur_y, i_cur_x, i_ref_y, i_ref_x}),
        .o_empty (q_empty),
        .i_pop   (q_pop),
        .o_item  (q_item)
    );

    emsc_back #(
        .COEF_WIDTH  (COEF_WIDTH),
        .COORD_WIDTH (COORD_WIDTH),
        .SCORE_WIDTH (SCORE_WIDTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (q_empty),
        .o_q_pop           (q_pop),
        .i_q_item          (q_item),
        .i_rows            (r_row),
        .i_chi             (r_chi),
        .i_bonus           (r_bonus),
        .o_empty           (empty),
        .i_pop             (pop),
        .o_total_score     (o_total_score),
        .o_score_saturated (o_score_saturated),
        .o_degenerate_seen (o_degenerate_seen)
    );

endmodule

// ===== hdl/emsc_checker.sv =====
module emsc_checker #(
    parameter int SCORE_WIDTH = 36
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   full,
    input logic                   empty,
    input logic                   pop,
    input logic [SCORE_WIDTH-1:0] o_total_score,
    input logic                   o_score_saturated
);

    // Reset leaves no result waiting and room for input
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    // A clipped total reads as the maximum
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_score_saturated) |-> (&o_total_score))
        else $error("saturated total below maximum");

    // A waiting result holds until popped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_total_score)))
        else $error("result changed while waiting");

endmodule

bind epipolar_model_score emsc_checker #(.SCORE_WIDTH(SCORE_WIDTH)) u_emsc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .full              (full),
    .empty             (empty),
    .pop               (pop),
    .o_total_score     (o_total_score),
    .o_score_saturated (o_score_saturated)
);
